[rtl/core/ssit_pkg.sv]
// ----------------------------------------------------------------------------
// ssit_pkg
// Types and codes shared by the stable sorted insert table.
// ----------------------------------------------------------------------------
package ssit_pkg;

  localparam int IdW     = 16;
  localparam int RatingW = 3;
  localparam int StatusW = 2;

  localparam logic [RatingW-1:0] RATING_MAX = 3'd4;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  localparam logic [StatusW-1:0] ST_INSERTED = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatusW-1:0] ST_ENTRY    = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [RatingW-1:0] rating;
  } entry_t;

endpackage

[rtl/core/ssit_if.sv]
// ----------------------------------------------------------------------------
// ssit_in_if / ssit_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ssit_in_if
  import ssit_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               action;
  logic [IdW-1:0]     entry_id;
  logic [RatingW-1:0] rating;

  modport source (output valid, action, entry_id, rating, input ready);
  modport sink   (input valid, action, entry_id, rating, output ready);
endinterface

interface ssit_out_if
  import ssit_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     out_id;
  logic [RatingW-1:0] out_rating;
  logic               last;

  modport source (output valid, status, out_id, out_rating, last, input ready);
  modport sink   (input valid, status, out_id, out_rating, last, output ready);
endinterface

[rtl/core/ssit_mem.sv]
// ----------------------------------------------------------------------------
// ssit_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssit_mem
  import ssit_pkg::*;
#(
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/stable_sorted_insert_table_unit.sv]
// ----------------------------------------------------------------------------
// stable_sorted_insert_table_unit
// Bounded table of (id, rating) entries kept in ascending rating order.
// ----------------------------------------------------------------------------
// One item is handled at a time. An insert into a table of n entries walks
// the entry store from the tail, moving each entry with a higher rating up by
// one place at one entry per cycle, so that anywhere from none to all n entries
// move. Inserts into an empty or full table finish in the idle state, their
// result showing in the next cycle. A readout passes through an address state
// and a wait state for each entry, set by the store's registered read, plus
// any output stall. Entries beyond the fill count are never used, so no
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module stable_sorted_insert_table_unit
  import ssit_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  ssit_in_if.sink     req,
  ssit_out_if.source  rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CountMax = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_RD_ADDR,
    S_RD_WAIT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  entry_t             new_entry;

  logic               o_valid;
  logic [StatusW-1:0] o_status;
  entry_t             o_entry;
  logic               o_last;

  logic               out_free;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_rdata;
  entry_t             req_entry;
  logic [CW-1:0]      count_m1;
  logic               rd_last;

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign count_m1  = count - 1'b1;
  assign rd_last   = (CW'(idx) == count_m1);

  assign req_entry.id     = req.entry_id;
  assign req_entry.rating = (req.rating > RATING_MAX) ? RATING_MAX : req.rating;

  ssit_mem #(.Depth(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read address: the tail on insert, two below the write slot while
  // shifting, the current slot on readout. Writes never hit the slot in flight.
  always_comb begin
    mem_raddr = '0;
    unique case (state) inside
      S_IDLE:    mem_raddr = (req.action == ACT_INSERT) ? count_m1[AW-1:0] : '0;
      S_SHIFT:   mem_raddr = idx - AW'(2);
      S_RD_ADDR,
      S_RD_WAIT: mem_raddr = idx;
      default:   mem_raddr = '0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = new_entry;
    unique case (state)
      S_IDLE: begin
        if (req.valid && req.ready && req.action == ACT_INSERT && count == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = req_entry;
        end
      end
      S_SHIFT: begin
        if (mem_rdata.rating > new_entry.rating) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      S_PLACE: begin
        mem_we = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      idx     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            new_entry <= req_entry;
            o_entry   <= '0;
            o_last    <= 1'b1;
            if (req.action == ACT_INSERT) begin
              if (count == CountMax) begin
                o_valid  <= 1'b1;
                o_status <= ST_FULL;
              end else if (count == '0) begin
                o_valid  <= 1'b1;
                o_status <= ST_INSERTED;
                count    <= count + 1'b1;
              end else begin
                idx   <= count[AW-1:0];
                state <= S_SHIFT;
              end
            end else begin
              if (count == '0) begin
                o_valid  <= 1'b1;
                o_status <= ST_EMPTY;
              end else begin
                idx   <= '0;
                state <= S_RD_ADDR;
              end
            end
          end
        end
        S_SHIFT: begin
          if (mem_rdata.rating > new_entry.rating) begin
            idx <= idx - 1'b1;
            if (idx == AW'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_status <= ST_INSERTED;
            o_entry  <= '0;
            o_last   <= 1'b1;
            count    <= count + 1'b1;
            state    <= S_IDLE;
          end
        end
        S_RD_ADDR: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_status <= ST_ENTRY;
            o_entry  <= mem_rdata;
            o_last   <= rd_last;
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD_ADDR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.status     = o_status;
  assign rsp.out_id     = o_entry.id;
  assign rsp.out_rating = o_entry.rating;
  assign rsp.last       = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountMax)
    else $error("fill count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |-> count == $past(count) + 1'b1)
    else $error("fill count moved by other than one");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT || state == S_PLACE) |-> count < CountMax)
    else $error("insert walk on a full table");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> count == CountMax)
    else $error("full item while table has room");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_ADDR || state == S_RD_WAIT) |-> CW'(idx) < count)
    else $error("readout beyond fill count");

endmodule

[tb/sv/tb_stable_sorted_insert_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_stable_sorted_insert_table_unit
// Self-checking bench for the stable sorted insert table.
// ----------------------------------------------------------------------------
// A short table of directed items covers the empty readout, the id and rating
// extremes, ratings above four and ties on equal ratings. Random inserts and
// readouts follow, filling the table until inserts are dropped as full. Every
// accepted request is run through a local model of the sorted table, and each
// result item is checked field by field against the oldest expectation. Both
// channels idle at random in the first two of three phases and not in the last,
// draining all results in between.
module tb_stable_sorted_insert_table_unit;
  import ssit_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 280;
  localparam int STALL_LIMIT  = 2000;
  localparam int N_DIRECTED   = 15;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [RatingW-1:0] rating;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               action;
    logic [IdW-1:0]     id;
    logic [RatingW-1:0] rating;
    logic               typed;
    logic [StatusW-1:0] status;
  } stim_row_t;

  logic clk;
  logic rst;

  ssit_in_if  req_ch ();
  ssit_out_if rsp_ch ();

  stable_sorted_insert_table_unit #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  entry_t             sorted_table[$];
  result_t            pending_results[$];
  int                 errors;
  int                 stall_cycles;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  logic               row_typed;
  logic [StatusW-1:0] row_status;
  stim_row_t          directed_rows [N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Model of the table: stable insert after every entry of rating <= key.
  task automatic table_apply(input logic act, input logic [IdW-1:0] id,
                             input logic [RatingW-1:0] rt, input logic typed,
                             input logic [StatusW-1:0] typed_status);
    result_t                r;
    entry_t                 e;
    int                     pos;
    logic [RatingW-1:0]     key;
    key      = (rt > RATING_MAX) ? RATING_MAX : rt;
    r.status = ST_INSERTED;
    r.id     = '0;
    r.rating = '0;
    r.last   = 1'b1;
    if (act == ACT_INSERT) begin
      if (sorted_table.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_table.size() && sorted_table[pos].rating <= key) pos++;
        e.id     = id;
        e.rating = key;
        sorted_table.insert(pos, e);
      end
      if (typed) r.status = typed_status;
      pending_results.push_back(r);
    end else if (sorted_table.size() == 0) begin
      r.status = typed ? typed_status : ST_EMPTY;
      pending_results.push_back(r);
    end else begin
      for (int i = 0; i < sorted_table.size(); i++) begin
        r.status = ST_ENTRY;
        r.id     = sorted_table[i].id;
        r.rating = sorted_table[i].rating;
        r.last   = (i == sorted_table.size() - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        table_apply(req_ch.action, req_ch.entry_id, req_ch.rating, row_typed, row_status);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d id %0h rating %0d last %0b",
                 rsp_ch.status, rsp_ch.out_id, rsp_ch.out_rating, rsp_ch.last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.out_id !== want.id) begin
            $error("out_id: expected %0h, actual %0h", want.id, rsp_ch.out_id);
            errors++;
          end
          if (rsp_ch.out_rating !== want.rating) begin
            $error("out_rating: expected %0d, actual %0d", want.rating, rsp_ch.out_rating);
            errors++;
          end
          if (rsp_ch.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [IdW-1:0] id,
                           input logic [RatingW-1:0] rt, input logic typed,
                           input logic [StatusW-1:0] st);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.entry_id <= id;
    req_ch.rating   <= rt;
    row_typed       <= typed;
    row_status      <= st;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic               act;
    logic [IdW-1:0]     id;
    logic [RatingW-1:0] rt;
    int                 ins_pct;
    send_idle_pct   = 8;
    recv_idle_pct   = 46;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_INSERT;
    req_ch.entry_id <= '0;
    req_ch.rating   <= '0;
    row_typed       <= 1'b0;
    row_status      <= ST_INSERTED;

    directed_rows = '{
      '{ACT_READOUT, 16'h0000, 3'd0, 1'b1, ST_EMPTY},
      '{ACT_INSERT,  16'hFFFF, 3'd4, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'h0000, 3'd0, 1'b1, ST_INSERTED},
      '{ACT_READOUT, 16'hFFFF, 3'd7, 1'b0, ST_ENTRY},
      '{ACT_INSERT,  16'h1234, 3'd7, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'h5555, 3'd5, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'hAAAA, 3'd6, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'h0001, 3'd2, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'h8000, 3'd2, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'h7FFF, 3'd3, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'h00FF, 3'd1, 1'b1, ST_INSERTED},
      '{ACT_INSERT,  16'hFF00, 3'd0, 1'b1, ST_INSERTED},
      '{ACT_READOUT, 16'h0000, 3'd0, 1'b0, ST_ENTRY},
      '{ACT_INSERT,  16'h4321, 3'd4, 1'b1, ST_INSERTED},
      '{ACT_READOUT, 16'h5A5A, 3'd3, 1'b0, ST_ENTRY}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++)
      send_item(directed_rows[k].action, directed_rows[k].id, directed_rows[k].rating,
                directed_rows[k].typed, directed_rows[k].status);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        drain_results();
        send_idle_pct = 46;
        recv_idle_pct = 8;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // grow slowly so readouts see many fill levels before the table is full
      ins_pct = (sorted_table.size() < CAPACITY) ? 35 : 50;
      act     = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_READOUT;
      case ($urandom_range(9))
        0:       id = '0;
        1:       id = '1;
        default: id = IdW'($urandom_range(65535));
      endcase
      if ($urandom_range(9) < 7)
        rt = RatingW'($urandom_range(4));
      else
        rt = RatingW'($urandom_range(7, 5));
      send_item(act, id, rt, 1'b0, ST_INSERTED);
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
